// ----- sv/glbp_pkg.sv -----
// Shared types and constants of the group L2 ball projection unit.
// No dependencies; all other files refer to it by scoped names.
`default_nettype none

package glbp_pkg;

   localparam int VALUE_W    = 24;
   localparam int WEIGHT_W   = 24;
   localparam int SCALE_W    = 24;
   localparam int SQUARE_W   = 47;
   localparam int SUM_W      = 53;
   localparam int NORM_W     = 27;
   localparam int RADIUS_W   = 32;
   localparam int SRADIUS_W  = 26;
   localparam int PRODUCT_W  = 48;
   localparam int DIVIDEND_W = 50;
   localparam int QUOT_W     = 24;

   localparam logic [SCALE_W-1:0]   SCALE_RESET = 24'd65536;
   localparam logic [PRODUCT_W-1:0] ROUND_HALF  = 48'd32768;
   localparam logic [QUOT_W-1:0]    POS_LIMIT   = 24'd8388607;
   localparam logic [QUOT_W-1:0]    NEG_LIMIT   = 24'd8388608;

   typedef struct packed {
      logic load;
      logic square;
      logic radius;
      logic sqrt_start;
      logic compare;
      logic read;
      logic mul;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic sqrt_done;
      logic div_done;
      logic shrink;
      logic last_emit;
   } status_type;

endpackage

`default_nettype wire

// ----- sv/glbp_sqrt.sv -----
// Iterative rounded square root, one result bit per cycle.
// Depends on glbp_pkg for widths.
`default_nettype none

module glbp_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [glbp_pkg::SUM_W-1:0]     radicand,
   output logic                           done,
   output logic [glbp_pkg::NORM_W-1:0]    root
);

   localparam int RAD_W  = 2 * glbp_pkg::NORM_W;
   localparam int REM_W  = glbp_pkg::NORM_W + 2;
   localparam int CNT_W  = $clog2(glbp_pkg::NORM_W);

   logic [RAD_W-1:0]            rad_ff;
   logic [REM_W-1:0]            rem_ff;
   logic [glbp_pkg::NORM_W-1:0] root_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        run_ff;
   logic                        done_ff;

   logic [REM_W+1:0]            rem_sh;
   logic [REM_W+1:0]            trial;
   logic                        ge;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(glbp_pkg::NORM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {1'b0, radicand};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
         root_ff <= {root_ff[glbp_pkg::NORM_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff + glbp_pkg::NORM_W'(rem_ff > {2'b00, root_ff});

endmodule

`default_nettype wire

// ----- sv/glbp_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on glbp_pkg for widths.
`default_nettype none

module glbp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [glbp_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [glbp_pkg::NORM_W-1:0]       divisor,
   output logic                              done,
   output logic [glbp_pkg::QUOT_W-1:0]       quotient
);

   localparam int QW    = glbp_pkg::QUOT_W;
   localparam int NW    = glbp_pkg::NORM_W;
   localparam int CNT_W = $clog2(QW);

   logic [NW-1:0]    rem_ff;
   logic [QW-1:0]    dvd_ff;
   logic [QW-1:0]    quot_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   logic [NW:0]      rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff, dvd_ff[QW-1]};
   assign ge     = rem_sh >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= NW'(dividend[glbp_pkg::DIVIDEND_W-1:QW]);
         dvd_ff  <= dividend[QW-1:0];
         quot_ff <= '0;
      end else if (run_ff) begin
         rem_ff  <= ge ? NW'(rem_sh - {1'b0, divisor}) : NW'(rem_sh);
         dvd_ff  <= {dvd_ff[QW-2:0], 1'b0};
         quot_ff <= {quot_ff[QW-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- sv/glbp_ctrl.sv -----
// Controller state machine: sequences accumulation, norm, compare and emission.
// Depends on glbp_pkg for the command and status structs.
`default_nettype none

module glbp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  glbp_pkg::status_type   status,
   output glbp_pkg::cmd_type      cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SQUARE    = 4'd1;
   localparam logic [3:0] S_ADD       = 4'd2;
   localparam logic [3:0] S_SQRT_GO   = 4'd3;
   localparam logic [3:0] S_SQRT_WAIT = 4'd4;
   localparam logic [3:0] S_COMPARE   = 4'd5;
   localparam logic [3:0] S_READ      = 4'd6;
   localparam logic [3:0] S_MUL       = 4'd7;
   localparam logic [3:0] S_DIV_GO    = 4'd8;
   localparam logic [3:0] S_DIV_WAIT  = 4'd9;
   localparam logic [3:0] S_EMIT      = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = status.close ? S_ADD : S_IDLE;
         end
         S_ADD: begin
            cmd.radius = 1'b1;
            state_in   = S_SQRT_GO;
         end
         S_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = status.shrink ? S_DIV_GO : S_EMIT;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.last_emit ? S_IDLE : S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

`default_nettype wire

// ----- sv/glbp_dpath.sv -----
// Datapath: element buffer, sum of squares, radius, norm, scaling and output registers.
// Depends on glbp_pkg, glbp_sqrt and glbp_div.
`default_nettype none

module glbp_dpath #(
   parameter int MAX_GROUP_LEN = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  glbp_pkg::cmd_type                      cmd,
   output glbp_pkg::status_type                   status,
   input  logic signed [glbp_pkg::VALUE_W-1:0]    req_value,
   input  logic [glbp_pkg::WEIGHT_W-1:0]          req_group_weight,
   input  logic                                   req_last_in_group,
   input  logic                                   csr_write_enable,
   input  logic [glbp_pkg::SCALE_W-1:0]           csr_write_data,
   output logic                                   rsp_strobe,
   output logic signed [glbp_pkg::VALUE_W-1:0]    rsp_projected_value,
   output logic [glbp_pkg::NORM_W-1:0]            rsp_group_norm,
   output logic                                   rsp_last_of_group
);

   localparam int VW = glbp_pkg::VALUE_W;
   localparam int NW = glbp_pkg::NORM_W;
   localparam int AW = (MAX_GROUP_LEN > 1) ? $clog2(MAX_GROUP_LEN) : 1;
   localparam int CW = $clog2(MAX_GROUP_LEN + 1);

   logic [VW-1:0]                      buffer_mem [MAX_GROUP_LEN];

   logic [glbp_pkg::SCALE_W-1:0]       scale_ff;
   logic [CW-1:0]                      count_ff;
   logic [CW-1:0]                      count_in;
   logic [CW-1:0]                      emit_idx_ff;
   logic signed [VW-1:0]               val_ff;
   logic [glbp_pkg::WEIGHT_W-1:0]      weight_ff;
   logic                               close_ff;
   logic [glbp_pkg::SQUARE_W-1:0]      sq_ff;
   logic                               sq_pend_ff;
   logic [glbp_pkg::SUM_W-1:0]         sum_ff;
   logic [glbp_pkg::PRODUCT_W-1:0]     prod_ff;
   logic [glbp_pkg::RADIUS_W-1:0]      radius_ff;
   logic [NW-1:0]                      norm_ff;
   logic                               shrink_ff;
   logic [VW-1:0]                      rd_ff;
   logic [glbp_pkg::DIVIDEND_W-1:0]    mprod_ff;

   logic                               rsp_strobe_ff;
   logic [VW-1:0]                      rsp_value_ff;
   logic [NW-1:0]                      rsp_norm_ff;
   logic                               rsp_last_ff;

   logic signed [2*VW-1:0]             square_full;
   logic [glbp_pkg::PRODUCT_W-1:0]     radius_sum;
   logic [VW-1:0]                      rd_mag;
   logic [glbp_pkg::DIVIDEND_W-1:0]    dividend;
   logic                               sqrt_done;
   logic [NW-1:0]                      sqrt_root;
   logic                               div_done;
   logic [glbp_pkg::QUOT_W-1:0]        quotient;
   logic                               last_emit;
   logic [VW-1:0]                      scaled;

   assign square_full = val_ff * val_ff;
   assign radius_sum  = prod_ff + glbp_pkg::ROUND_HALF;
   assign rd_mag      = rd_ff[VW-1] ? VW'(~rd_ff + 1'b1) : rd_ff;
   assign dividend    = mprod_ff + glbp_pkg::DIVIDEND_W'(norm_ff >> 1);
   assign last_emit   = (emit_idx_ff + 1'b1) == count_ff;

   always_comb begin
      if (rd_ff[VW-1]) begin
         scaled = (quotient > glbp_pkg::NEG_LIMIT) ? VW'(0 - glbp_pkg::NEG_LIMIT)
                                                   : VW'(0 - quotient);
      end else begin
         scaled = (quotient > glbp_pkg::POS_LIMIT) ? glbp_pkg::POS_LIMIT : quotient;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.emit && last_emit) begin
         count_in = '0;
      end
   end

   glbp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   glbp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (norm_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         buffer_mem[count_ff[AW-1:0]] <= req_value;
      end
      if (cmd.read) begin
         rd_ff <= buffer_mem[emit_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= glbp_pkg::SCALE_RESET;
         count_ff      <= '0;
         emit_idx_ff   <= '0;
         sq_pend_ff    <= 1'b0;
         sum_ff        <= '0;
         shrink_ff     <= 1'b0;
         close_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            scale_ff <= csr_write_data;
         end
         count_ff      <= count_in;
         sq_pend_ff    <= cmd.square;
         rsp_strobe_ff <= cmd.emit;
         if (cmd.load) begin
            close_ff <= req_last_in_group || (count_ff == CW'(MAX_GROUP_LEN - 1));
         end
         if (sq_pend_ff) begin
            sum_ff <= sum_ff + glbp_pkg::SUM_W'(sq_ff);
         end else if (cmd.emit && last_emit) begin
            sum_ff <= '0;
         end
         if (cmd.compare) begin
            shrink_ff   <= glbp_pkg::RADIUS_W'(norm_ff) > radius_ff;
            emit_idx_ff <= '0;
         end else if (cmd.emit) begin
            emit_idx_ff <= emit_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff    <= req_value;
         weight_ff <= req_group_weight;
      end
      if (cmd.square) begin
         sq_ff   <= glbp_pkg::SQUARE_W'(square_full);
         prod_ff <= scale_ff * weight_ff;
      end
      if (cmd.radius) begin
         radius_ff <= radius_sum[glbp_pkg::PRODUCT_W-1:16];
      end
      if (sqrt_done) begin
         norm_ff <= sqrt_root;
      end
      if (cmd.mul) begin
         mprod_ff <= rd_mag * radius_ff[glbp_pkg::SRADIUS_W-1:0];
      end
      if (cmd.emit) begin
         rsp_value_ff <= shrink_ff ? scaled : rd_ff;
         rsp_norm_ff  <= (last_emit && shrink_ff) ? norm_ff : '0;
         rsp_last_ff  <= last_emit;
      end
   end

   always_comb begin
      status           = '0;
      status.close     = close_ff;
      status.sqrt_done = sqrt_done;
      status.div_done  = div_done;
      status.shrink    = shrink_ff;
      status.last_emit = last_emit;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_projected_value = rsp_value_ff;
   assign rsp_group_norm      = rsp_norm_ff;
   assign rsp_last_of_group   = rsp_last_ff;

endmodule

`default_nettype wire

// ----- sv/group_l2_ball_projection_unit.sv -----
// Top level of the group L2 ball projection unit.
// Depends on glbp_pkg, glbp_ctrl and glbp_dpath.
//
// Usage:
//   Input: an item (req_value, req_group_weight, req_last_in_group) is taken
//   at a rising edge with start high and busy low. Items of one group come in
//   order; the item with req_last_in_group set, or the MAX_GROUP_LEN-th item,
//   closes the group and its weight sets the radius.
//   Output: one result per buffered item, each shown for exactly one cycle
//   with rsp_strobe high; rsp_last_of_group marks the final one, which also
//   carries the group norm when the group was scaled, else zero.
//   Config: csr_write_enable loads csr_write_data into the radius scale.
//   Sequence: an item that does not close a group is buffered and squared.
//   A closing item goes on through the sum, radius, the 27-step square root
//   and the compare, then each result is read and multiplied and, when the
//   group is scaled, divided by the 24-step divider before it is emitted.
//   Reset: synchronous; clears the group, the pending results and sets the
//   radius scale to 1.0. The buffer needs no clearing.
//   Results cannot be stalled; the receiver must take every strobe.
`default_nettype none

module group_l2_ball_projection_unit #(
   parameter int MAX_GROUP_LEN = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [glbp_pkg::VALUE_W-1:0]    req_value,
   input  logic [glbp_pkg::WEIGHT_W-1:0]          req_group_weight,
   input  logic                                   req_last_in_group,
   output logic                                   rsp_strobe,
   output logic signed [glbp_pkg::VALUE_W-1:0]    rsp_projected_value,
   output logic [glbp_pkg::NORM_W-1:0]            rsp_group_norm,
   output logic                                   rsp_last_of_group,
   input  logic                                   csr_write_enable,
   input  logic [glbp_pkg::SCALE_W-1:0]           csr_write_data
);

   glbp_pkg::cmd_type    cmd;
   glbp_pkg::status_type status;

   glbp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   glbp_dpath #(
      .MAX_GROUP_LEN (MAX_GROUP_LEN)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_value           (req_value),
      .req_group_weight    (req_group_weight),
      .req_last_in_group   (req_last_in_group),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_projected_value (rsp_projected_value),
      .rsp_group_norm      (rsp_group_norm),
      .rsp_last_of_group   (rsp_last_of_group)
   );

endmodule

`default_nettype wire

// ----- sv/glbp_checker.sv -----
// Port-level checks of the group L2 ball projection unit and their bind.
// Depends on glbp_pkg and group_l2_ball_projection_unit.
`default_nettype none

module glbp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_strobe,
   input logic [glbp_pkg::NORM_W-1:0]          rsp_group_norm,
   input logic                                 rsp_last_of_group
);

   assert property (@(posedge clock) reset |=> !rsp_strobe && !busy)
      else $error("strobe or busy after reset");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy))
      else $error("result without prior work");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_of_group) |-> rsp_group_norm == '0)
      else $error("norm reported before end of group");

endmodule

bind group_l2_ball_projection_unit glbp_checker u_glbp_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_group_norm    (rsp_group_norm),
   .rsp_last_of_group (rsp_last_of_group)
);

`default_nettype wire

// ----- tb/glbp_projection_checker.sv -----
// Predictor and scoreboard for the group L2 ball projection unit.
// Watches the item, result and register ports; needs glbp_pkg.
`timescale 1ns / 1ps

module glbp_projection_checker #(
   parameter int MAX_GROUP_LEN = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [glbp_pkg::VALUE_W-1:0] req_value,
   input  logic [glbp_pkg::WEIGHT_W-1:0]       req_group_weight,
   input  logic                                req_last_in_group,
   input  logic                                rsp_strobe,
   input  logic signed [glbp_pkg::VALUE_W-1:0] rsp_projected_value,
   input  logic [glbp_pkg::NORM_W-1:0]         rsp_group_norm,
   input  logic                                rsp_last_of_group,
   input  logic                                csr_write_enable,
   input  logic [glbp_pkg::SCALE_W-1:0]        csr_write_data,
   output int                                  mismatch_count,
   output int                                  pending_results,
   output int                                  results_seen,
   output int                                  closed_groups,
   output int                                  scaled_groups
);

   localparam int REPORT_LINES = 30;

   typedef struct packed {
      logic signed [glbp_pkg::VALUE_W-1:0] value;
      logic [glbp_pkg::NORM_W-1:0]         norm;
      logic                                last;
   } projection_type;

   projection_type                      projection_queue[$];
   logic signed [glbp_pkg::VALUE_W-1:0] group_buffer[MAX_GROUP_LEN];
   logic [63:0]                         square_total;
   int                                  group_fill;
   logic [glbp_pkg::SCALE_W-1:0]        scale_setting;

   function automatic logic [63:0] nearest_root(input logic [63:0] radicand);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] bitpos;
      rest = radicand;
      root = '0;
      bitpos = 64'd1 << 62;
      while (bitpos > rest) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (rest >= root + bitpos) begin
            rest = rest - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      if (rest > root) root = root + 1;
      return root;
   endfunction

   function automatic logic signed [glbp_pkg::VALUE_W-1:0] shrink_element(
      input logic signed [glbp_pkg::VALUE_W-1:0] element,
      input logic [63:0] radius,
      input logic [63:0] norm
   );
      logic signed [63:0] wide;
      logic [63:0]        magnitude;
      logic [63:0]        quotient;
      logic [63:0]        limit;
      wide = element;
      magnitude = (wide < 0) ? -wide : wide;
      quotient = (magnitude * radius + (norm >> 1)) / norm;
      limit = (wide < 0) ? 64'(glbp_pkg::NEG_LIMIT) : 64'(glbp_pkg::POS_LIMIT);
      if (quotient > limit) quotient = limit;
      if (wide < 0) quotient = -quotient;
      return quotient[glbp_pkg::VALUE_W-1:0];
   endfunction

   task automatic report_mismatch(input string message);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) $display("[%0t] MISMATCH: %s", $realtime, message);
   endtask

   task automatic absorb_item(
      input logic signed [glbp_pkg::VALUE_W-1:0] value,
      input logic [glbp_pkg::WEIGHT_W-1:0]       weight,
      input logic                                closes
   );
      logic signed [63:0] wide_value;
      logic [63:0]        wide_scale;
      logic [63:0]        wide_weight;
      logic [63:0]        norm;
      logic [63:0]        radius;
      logic               scaled;
      projection_type     entry;
      wide_value = value;
      group_buffer[group_fill] = value;
      group_fill++;
      square_total = square_total + 64'(wide_value * wide_value);
      if (closes || group_fill == MAX_GROUP_LEN) begin
         wide_scale = scale_setting;
         wide_weight = weight;
         norm = nearest_root(square_total);
         radius = (wide_scale * wide_weight + 64'(glbp_pkg::ROUND_HALF)) >> 16;
         scaled = norm > radius;
         for (int k = 0; k < group_fill; k++) begin
            entry.value = scaled ? shrink_element(group_buffer[k], radius, norm)
                                 : group_buffer[k];
            entry.last = (k == group_fill - 1);
            entry.norm = (entry.last && scaled) ? norm[glbp_pkg::NORM_W-1:0] : '0;
            projection_queue.push_back(entry);
         end
         closed_groups++;
         if (scaled) scaled_groups++;
         square_total = '0;
         group_fill = 0;
      end
   endtask

   always @(posedge clock) begin
      projection_type want;
      if (reset) begin
         projection_queue.delete();
         square_total = '0;
         group_fill = 0;
         scale_setting = glbp_pkg::SCALE_RESET;
         mismatch_count = 0;
         results_seen = 0;
         closed_groups = 0;
         scaled_groups = 0;
      end else begin
         if (rsp_strobe) begin
            results_seen++;
            if (projection_queue.size() == 0) begin
               report_mismatch($sformatf("unpredicted item value %0d norm %0d last %0b",
                                         rsp_projected_value, rsp_group_norm,
                                         rsp_last_of_group));
            end else begin
               want = projection_queue.pop_front();
               if (rsp_projected_value !== want.value)
                  report_mismatch($sformatf("projected value %0d, predicted %0d",
                                            rsp_projected_value, want.value));
               if (rsp_group_norm !== want.norm)
                  report_mismatch($sformatf("group norm %0d, predicted %0d",
                                            rsp_group_norm, want.norm));
               if (rsp_last_of_group !== want.last)
                  report_mismatch($sformatf("last flag %0b, predicted %0b",
                                            rsp_last_of_group, want.last));
            end
         end
         if (csr_write_enable) scale_setting = csr_write_data;
         if (start && !busy) absorb_item(req_value, req_group_weight, req_last_in_group);
      end
      pending_results = projection_queue.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Stimulus and verdict for the group L2 ball projection unit.
// Needs glbp_pkg, group_l2_ball_projection_unit and glbp_projection_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int GROUP_LIMIT   = 64;
   localparam int PHASE_ITEMS   = 20;
   localparam int PHASE_COUNT   = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 64;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum int {NO_LONG_GROUP, LONG_UNFLAGGED, LONG_FLAGGED} long_group_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [glbp_pkg::VALUE_W-1:0] req_value;
   logic [glbp_pkg::WEIGHT_W-1:0]       req_group_weight;
   logic                                req_last_in_group;
   logic                                rsp_strobe;
   logic signed [glbp_pkg::VALUE_W-1:0] rsp_projected_value;
   logic [glbp_pkg::NORM_W-1:0]         rsp_group_norm;
   logic                                rsp_last_of_group;
   logic                                csr_write_enable;
   logic [glbp_pkg::SCALE_W-1:0]        csr_write_data;

   int mismatch_count;
   int pending_results;
   int results_seen;
   int closed_groups;
   int scaled_groups;

   int             cycle_count;
   int             items_sent;
   int             scale_writes;
   int             idle_pct;
   int             item_budget;
   long_group_type long_kind;
   logic [glbp_pkg::SCALE_W-1:0] scale_pick;

   group_l2_ball_projection_unit #(.MAX_GROUP_LEN(GROUP_LIMIT)) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .req_group_weight   (req_group_weight),
      .req_last_in_group  (req_last_in_group),
      .rsp_strobe         (rsp_strobe),
      .rsp_projected_value(rsp_projected_value),
      .rsp_group_norm     (rsp_group_norm),
      .rsp_last_of_group  (rsp_last_of_group),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   glbp_projection_checker #(.MAX_GROUP_LEN(GROUP_LIMIT)) projection_watch (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .req_group_weight   (req_group_weight),
      .req_last_in_group  (req_last_in_group),
      .rsp_strobe         (rsp_strobe),
      .rsp_projected_value(rsp_projected_value),
      .rsp_group_norm     (rsp_group_norm),
      .rsp_last_of_group  (rsp_last_of_group),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .pending_results    (pending_results),
      .results_seen       (results_seen),
      .closed_groups      (closed_groups),
      .scaled_groups      (scaled_groups)
   );

   initial clock = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("group_l2_ball_projection_unit regression: fail");
         $finish;
      end
   end

   function automatic logic [glbp_pkg::VALUE_W-1:0] pick_value();
      logic [glbp_pkg::VALUE_W-1:0] magnitude;
      case ($urandom_range(0, 5))
         0: return 24'($urandom);
         1: magnitude = 24'($urandom_range(0, 1023));
         2: begin
            case ($urandom_range(0, 3))
               0: return 24'h7FFFFF;
               1: return 24'h800000;
               2: return 24'h000000;
               default: return 24'hFFFFFF;
            endcase
         end
         default: magnitude = 24'($urandom_range(0, 1 << 20));
      endcase
      return $urandom_range(0, 1) ? -magnitude : magnitude;
   endfunction

   function automatic logic [glbp_pkg::WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 4))
         0: return 24'($urandom);
         1: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         2: return 24'($urandom_range(0, 1 << 12));
         default: return 24'($urandom_range(0, 1 << 18));
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(
      input logic [glbp_pkg::VALUE_W-1:0]  value,
      input logic [glbp_pkg::WEIGHT_W-1:0] weight,
      input logic                          last
   );
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_value = value;
      req_group_weight = weight;
      req_last_in_group = last;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic run_group(input int length, input logic flag_last);
      for (int i = 0; i < length; i++)
         send_item(pick_value(), pick_weight(), flag_last && (i == length - 1));
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_results != 0 || busy) @(negedge clock);
   endtask

   task automatic write_scale(input logic [glbp_pkg::SCALE_W-1:0] scale);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = scale;
      @(negedge clock);
      csr_write_enable = 1'b0;
      scale_writes++;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      req_group_weight = '0;
      req_last_in_group = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      items_sent = 0;
      scale_writes = 0;
      idle_pct = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // zero norm, zero radius, full weight, then mixed groups at scale 1.0
      send_item(24'h000000, 24'h000000, 1'b1);
      send_item(24'h7FFFFF, 24'h000000, 1'b1);
      send_item(24'h800000, 24'hFFFFFF, 1'b1);
      send_item(24'h7FFFFF, 24'h010000, 1'b0);
      send_item(24'h800000, 24'h010000, 1'b0);
      send_item(24'h000001, 24'h010000, 1'b1);
      send_item(24'hFFFFFF, 24'h000001, 1'b0);
      send_item(24'h000001, 24'h000001, 1'b1);
      send_item(24'h123456, 24'h800000, 1'b0);
      send_item(24'hF54322, 24'h800000, 1'b0);
      send_item(24'h000000, 24'h800000, 1'b0);
      send_item(24'h7FFFFF, 24'h800000, 1'b0);
      send_item(24'h800000, 24'h800000, 1'b1);
      // only the closing weight sets the radius
      send_item(24'h400000, 24'hFFFFFF, 1'b0);
      send_item(24'hC00000, 24'hFFFFFF, 1'b0);
      send_item(24'h200000, 24'h000000, 1'b1);
      send_item(24'h555555, 24'hAAAAAA, 1'b0);
      send_item(24'hAAAAAA, 24'h555555, 1'b1);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               scale_pick = '0;
               idle_pct = 0;
               long_kind = NO_LONG_GROUP;
            end
            1: begin
               scale_pick = '1;
               idle_pct = 77;
               long_kind = NO_LONG_GROUP;
            end
            2: begin
               scale_pick = glbp_pkg::SCALE_RESET;
               idle_pct = 0;
               long_kind = LONG_UNFLAGGED;
            end
            3: begin
               scale_pick = 24'($urandom);
               idle_pct = 37;
               long_kind = LONG_FLAGGED;
            end
            default: begin
               scale_pick = 24'($urandom_range(16384, 262143));
               idle_pct = 77;
               long_kind = NO_LONG_GROUP;
            end
         endcase
         write_scale(scale_pick);
         if (long_kind != NO_LONG_GROUP) run_group(GROUP_LIMIT, long_kind == LONG_FLAGGED);
         item_budget = items_sent + PHASE_ITEMS;
         while (items_sent < item_budget) begin
            run_group($urandom_range(1, 8), 1'b1);
            if ($urandom_range(0, 9) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d items in %0d groups (%0d scaled down), %0d results compared",
               items_sent, closed_groups, scaled_groups, results_seen);
      $display("across %0d radius scale settings, long groups closed by flag and by length",
               scale_writes);
      if (mismatch_count == 0 && pending_results == 0)
         $display("group_l2_ball_projection_unit regression: pass");
      else
         $display("group_l2_ball_projection_unit regression: fail");
      $finish;
   end

endmodule
